FILE: rtl/core/bscs_pkg.sv
// ----------------------------------------------------------------------------
// bscs_pkg
// Shared types and constants of the byte stack core with spill memory.
// ----------------------------------------------------------------------------
package bscs_pkg;

   localparam int SPILL_DEPTH = 256;
   localparam int SPILL_AW    = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
   localparam int PTR_W       = $clog2(SPILL_DEPTH + 1);

   localparam int OP_W    = 4;
   localparam int BYTE_W  = 8;
   localparam int LIVE_W  = 2;
   localparam int DEPTH_W = 9;

   localparam logic [LIVE_W-1:0] LIVE_NONE = 2'd0;
   localparam logic [LIVE_W-1:0] LIVE_ONE  = 2'd1;
   localparam logic [LIVE_W-1:0] LIVE_TWO  = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 4'd0,
      OP_DUP   = 4'd1,
      OP_DROP  = 4'd2,
      OP_SWAP  = 4'd3,
      OP_OVER  = 4'd4,
      OP_ZERO  = 4'd5,
      OP_ADD   = 4'd6,
      OP_NAND  = 4'd7,
      OP_RESET = 4'd8
   } op_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  top_value;
      logic [BYTE_W-1:0]  second_value;
      logic [LIVE_W-1:0]  live_count;
      logic [DEPTH_W-1:0] spill_depth;
      logic               overflow;
   } rsp_type;

endpackage

FILE: rtl/core/byte_stack_core_with_spill_unit.sv
// ----------------------------------------------------------------------------
// byte_stack_core_with_spill_unit
// 8-bit stack core with two cached top registers and a spill memory below.
// ----------------------------------------------------------------------------
// an accepted item's result is registered in rsp_ff, or in skid_ff if stalled
// throughput: 1 item per cycle while req_stall is low, set by the single
//   registered pass and spill_top, which holds the entry below second
// a two-entry output buffer lets the core take items while a result waits
// reset: synchronous, clears top, second, live count, spill pointer, overflow
//   and the output buffer; spill memory contents are not cleared
module byte_stack_core_with_spill_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bscs_pkg::OP_W-1:0]    req_op,
   input  logic [bscs_pkg::BYTE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bscs_pkg::BYTE_W-1:0]  rsp_top_value,
   output logic [bscs_pkg::BYTE_W-1:0]  rsp_second_value,
   output logic [bscs_pkg::LIVE_W-1:0]  rsp_live_count,
   output logic [bscs_pkg::DEPTH_W-1:0] rsp_spill_depth,
   output logic                         rsp_overflow
);
   import bscs_pkg::*;

   logic [BYTE_W-1:0] top_ff, top_in;
   logic [BYTE_W-1:0] second_ff, second_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              ovf_ff, ovf_in;

   logic [BYTE_W-1:0] spill_mem [SPILL_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              byp_ff;
   logic [BYTE_W-1:0] byp_data_ff;
   logic [BYTE_W-1:0] spill_top;

   logic                wr_en;
   logic [SPILL_AW-1:0] wr_addr;
   logic [BYTE_W-1:0]   wr_data;
   logic [PTR_W-1:0]    ptr_next;
   logic [PTR_W-1:0]    rd_ptr;

   logic    accept;
   rsp_type new_rsp;
   rsp_type rsp_ff, rsp_in;
   rsp_type skid_ff;
   logic    rsp_valid_ff, skid_valid_ff;
   logic    out_fire;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_fire  = rsp_valid_ff && !rsp_stall;

   // entry just below second, with bypass for a spill written last cycle
   assign spill_top = byp_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      logic [BYTE_W-1:0] t, s, px;
      logic [LIVE_W-1:0] l;
      logic [PTR_W-1:0]  p;
      logic              o, push;
      logic [BYTE_W:0]   sum;
      t = top_ff;
      s = second_ff;
      l = live_ff;
      p = ptr_ff;
      o = ovf_ff;
      push = 1'b0;
      px = '0;
      sum = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = second_ff;
      unique case (op_type'(req_op))
         OP_PUSH: begin
            push = 1'b1;
            px = req_value;
         end
         OP_DUP: begin
            if (l >= LIVE_TWO) begin
               push = 1'b1;
               px = t;
            end else begin
               if (l == LIVE_NONE) t = '0;
               s = t;
               l = LIVE_TWO;
            end
         end
         OP_DROP: begin
            if (l >= LIVE_TWO) begin
               t = s;
               if (p == '0) begin
                  l = LIVE_ONE;
               end else begin
                  p = p - PTR_W'(1);
                  s = spill_top;
               end
            end else if (l == LIVE_ONE) begin
               l = LIVE_NONE;
               t = '0;
            end
         end
         OP_SWAP: begin
            if (l >= LIVE_TWO) begin
               t = second_ff;
               s = top_ff;
            end else if (l == LIVE_ONE) begin
               s = t;
               t = '0;
               l = LIVE_TWO;
            end
         end
         OP_OVER: begin
            if (l < LIVE_TWO) begin
               if (l == LIVE_NONE) t = '0;
               s = '0;
               l = LIVE_TWO;
            end
            push = 1'b1;
            px = s;
         end
         OP_ZERO: begin
            t = '0;
            s = '0;
            l = LIVE_TWO;
         end
         OP_ADD: begin
            if (l == LIVE_NONE) t = '0;
            if (l < LIVE_TWO) s = '0;
            l = LIVE_TWO;
            sum = {1'b0, s} + {1'b0, t};
            s = sum[BYTE_W-1:0];
            t = BYTE_W'(sum[BYTE_W]);
         end
         OP_NAND: begin
            if (l == LIVE_NONE) t = '0;
            if (l < LIVE_TWO) s = '0;
            l = LIVE_TWO;
            s = ~(s & t);
            t = s;
         end
         OP_RESET: begin
            p = '0;
            l = LIVE_NONE;
            o = 1'b0;
         end
         default: begin
         end
      endcase
      if (push) begin
         priority if (l >= LIVE_TWO && p == PTR_W'(SPILL_DEPTH)) begin
            // full spill: flag it and leave the stack as it is
            o = 1'b1;
         end else if (l >= LIVE_TWO) begin
            wr_en = accept;
            wr_addr = p[SPILL_AW-1:0];
            wr_data = s;
            p = p + PTR_W'(1);
            s = t;
            t = px;
         end else begin
            l = l + LIVE_W'(1);
            s = t;
            t = px;
         end
      end
      top_in = t;
      second_in = s;
      live_in = l;
      ptr_in = p;
      ovf_in = o;
   end

   assign ptr_next = accept ? ptr_in : ptr_ff;
   assign rd_ptr   = ptr_next - PTR_W'(1);

   always_comb begin
      new_rsp.top_value    = top_in;
      new_rsp.second_value = second_in;
      new_rsp.live_count   = live_in;
      new_rsp.spill_depth  = DEPTH_W'(ptr_in);
      new_rsp.overflow     = ovf_in;
      rsp_in = skid_valid_ff ? skid_ff : new_rsp;
   end

   always_ff @(posedge clock) begin
      if (wr_en) spill_mem[wr_addr] <= wr_data;
      rd_data_ff  <= spill_mem[rd_ptr[SPILL_AW-1:0]];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         second_ff <= '0;
         live_ff   <= LIVE_NONE;
         ptr_ff    <= '0;
         ovf_ff    <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         byp_ff <= wr_en;
         if (accept) begin
            top_ff    <= top_in;
            second_ff <= second_in;
            live_ff   <= live_in;
            ptr_ff    <= ptr_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || out_fire) begin
         rsp_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || out_fire) begin
         rsp_ff <= rsp_in;
      end else if (accept) begin
         skid_ff <= new_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_value    = rsp_ff.top_value;
   assign rsp_second_value = rsp_ff.second_value;
   assign rsp_live_count   = rsp_ff.live_count;
   assign rsp_spill_depth  = rsp_ff.spill_depth;
   assign rsp_overflow     = rsp_ff.overflow;

endmodule

FILE: rtl/core/bscs_checker.sv
// ----------------------------------------------------------------------------
// bscs_checker
// Port-level checks for the byte stack core, bound to byte_stack_core_with_spill_unit.
// ----------------------------------------------------------------------------
module bscs_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [bscs_pkg::OP_W-1:0]    req_op,
   input  logic [bscs_pkg::BYTE_W-1:0]  req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [bscs_pkg::BYTE_W-1:0]  rsp_top_value,
   input  logic [bscs_pkg::BYTE_W-1:0]  rsp_second_value,
   input  logic [bscs_pkg::LIVE_W-1:0]  rsp_live_count,
   input  logic [bscs_pkg::DEPTH_W-1:0] rsp_spill_depth,
   input  logic                         rsp_overflow
);
   import bscs_pkg::*;

   // a stalled input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_op) && $stable(req_value))
      else $error("stalled input item changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_second_value) && $stable(rsp_live_count)
         && $stable(rsp_spill_depth) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // spill holds data only while both top registers are live
   a_spill_needs_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_live_count != LIVE_TWO |-> rsp_spill_depth == '0)
      else $error("spill entries with fewer than two live registers");

   a_live_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_count <= LIVE_TWO && rsp_spill_depth <= SPILL_DEPTH)
      else $error("live count or spill depth out of range");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind byte_stack_core_with_spill_unit bscs_checker u_bscs_checker (.*);
